>>> hw/rtl/bpts_pkg.sv
// shared types, constants and helpers for the bitmap priority task scheduler
package bpts_pkg;

    localparam int TASK_MAX       = 32;
    localparam int TASK_COUNT_DEF = 32;
    localparam int TASK_IDX_W     = 5;
    localparam int PRIO_W         = 6;
    localparam int MSG_W          = 32;
    localparam int CFG_W          = 32;
    localparam int CNT_W          = 8;

    localparam logic [PRIO_W-1:0] NO_TASK = 6'd32;
    localparam logic [CNT_W-1:0]  CNT_MAX = 8'hFF;

    // request function codes
    typedef enum logic [3:0] {
        FN_START   = 4'd0,
        FN_SEND_T  = 4'd1,
        FN_SEND_I  = 4'd2,
        FN_PEND    = 4'd3,
        FN_RESUME  = 4'd4,
        FN_READY   = 4'd5,
        FN_UNREADY = 4'd6,
        FN_GET     = 4'd7,
        FN_CLEAR   = 4'd8,
        FN_LOCK    = 4'd9,
        FN_UNLOCK  = 4'd10,
        FN_RESCHED = 4'd11
    } func_t;

    typedef enum logic [1:0] {
        SW_NONE   = 2'd0,
        SW_THREAD = 2'd1,
        SW_IRQ    = 2'd2
    } switch_t;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_RANGE = 1'b1
    } status_t;

    // per-task table controls from the scheduler core
    typedef struct packed {
        logic                  dlv_en;
        logic                  pend_inc;
        logic                  pend_dec;
        logic [TASK_IDX_W-1:0] idx;
        logic [MSG_W-1:0]      msg;
        logic                  clr_en;
        logic [TASK_IDX_W-1:0] clr_idx;
        logic [TASK_IDX_W-1:0] rd_idx;
    } tbl_ctl_t;

    // per-task table status back to the core
    typedef struct packed {
        logic [TASK_MAX-1:0] pend_zero;
        logic [TASK_MAX-1:0] pend_one;
        logic [TASK_MAX-1:0] msg_zero;
        logic [MSG_W-1:0]    rd_word;
    } tbl_stat_t;

    typedef struct packed {
        status_t             status;
        switch_t             switch_kind;
        logic [PRIO_W-1:0]   running_prio;
        logic [MSG_W-1:0]    msg_out;
        logic [TASK_MAX-1:0] ready_bits;
    } result_t;

    // lowest set bit, NO_TASK when empty
    function automatic logic [PRIO_W-1:0] first_set(input logic [TASK_MAX-1:0] bits);
        logic [PRIO_W-1:0] pos;
        pos = NO_TASK;
        for (int i = TASK_MAX - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                pos = PRIO_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/bpts_req_if.sv
// request channel interface of the task scheduler
interface bpts_req_if;
    import bpts_pkg::*;

    logic              valid;
    logic              ready;
    logic [3:0]        func;
    logic [PRIO_W-1:0] task_prio;
    logic [MSG_W-1:0]  msg_in;

    modport source (output valid, output func, output task_prio, output msg_in, input ready);
    modport sink   (input valid, input func, input task_prio, input msg_in, output ready);
endinterface

>>> hw/rtl/bpts_rsp_if.sv
// response channel interface of the task scheduler
interface bpts_rsp_if;
    import bpts_pkg::*;

    logic                valid;
    logic                ready;
    logic                status;
    logic [1:0]          switch_kind;
    logic [PRIO_W-1:0]   running_prio;
    logic [MSG_W-1:0]    msg_out;
    logic [TASK_MAX-1:0] ready_bits;

    modport source (output valid, output status, output switch_kind, output running_prio,
                    output msg_out, output ready_bits, input ready);
    modport sink   (input valid, input status, input switch_kind, input running_prio,
                    input msg_out, input ready_bits, output ready);
endinterface

>>> hw/rtl/bitmap_priority_task_scheduler.sv
// top level of the bitmap priority task scheduler
// a request is held in the request register, then its result in the response register
// throughput: one request per cycle unless the response stalls; the core state update sets it
// the request register frees whenever the response register is empty or being taken
// reset: asynchronous active low; no ready task, running priority 32, counts and words zero
// created mask clears on reset; user writes it only with no request in flight; unenforced
module bitmap_priority_task_scheduler #(
    parameter int TASK_COUNT = bpts_pkg::TASK_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bpts_pkg::CFG_W-1:0] cfg_wr_data,
    bpts_req_if.sink                   req,
    bpts_rsp_if.source                 rsp
);
    import bpts_pkg::*;

    logic [CFG_W-1:0]  created_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic [3:0]        func_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [MSG_W-1:0]  msg_in_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic      out_free;
    logic      step;
    logic      accept;
    tbl_ctl_t  tbl_ctl;
    tbl_stat_t tbl_stat;
    result_t   result;

    // created mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            created_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            created_reg <= cfg_wr_data;
        end
    end

    // request and response handshakes
    assign out_free  = !out_valid_reg || rsp.ready;
    assign step      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= req.func;
            prio_reg   <= req.task_prio;
            msg_in_reg <= req.msg_in;
        end
    end

    // response payload register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    bpts_sched_core #(
        .TASK_COUNT (TASK_COUNT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .func         (func_reg),
        .task_prio    (prio_reg),
        .msg_in       (msg_in_reg),
        .created_mask (created_reg),
        .tbl_stat     (tbl_stat),
        .tbl_ctl      (tbl_ctl),
        .result       (result)
    );

    bpts_task_table #(
        .TASK_COUNT (TASK_COUNT)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tbl_ctl),
        .stat  (tbl_stat)
    );

    // response outputs
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.switch_kind  = out_reg.switch_kind;
    assign rsp.running_prio = out_reg.running_prio;
    assign rsp.msg_out      = out_reg.msg_out;
    assign rsp.ready_bits   = out_reg.ready_bits;

`ifndef SYNTH
    localparam logic [TASK_MAX-1:0] CHK_MASK = (TASK_COUNT >= TASK_MAX) ?
        {TASK_MAX{1'b1}} : TASK_MAX'((64'd1 << TASK_COUNT) - 64'd1);
    localparam logic [PRIO_W-1:0] CHK_LIMIT = PRIO_W'(TASK_COUNT);

    // no ready bit beyond the configured task count
    a_ready_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.ready_bits & ~CHK_MASK) == '0))
        else $error("ready bit set beyond task count");

    // running priority is a real task or none
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.running_prio == NO_TASK || rsp.running_prio < CHK_LIMIT))
        else $error("running priority out of range");

    // a failed request never switches context
    a_fail_noswitch: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_RANGE) |-> (rsp.switch_kind == SW_NONE))
        else $error("context switch on failed request");

    // request side stalls only when both stages are full and the response waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request stalled without backpressure");
`endif

endmodule

>>> hw/rtl/bpts_task_table.sv
// per-task pend counters and message words
module bpts_task_table #(
    parameter int TASK_COUNT = bpts_pkg::TASK_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpts_pkg::tbl_ctl_t  ctl,
    output bpts_pkg::tbl_stat_t stat
);
    import bpts_pkg::*;

    localparam int IDX_W = $clog2(TASK_COUNT);

    logic [CNT_W-1:0] pend_reg  [TASK_COUNT];
    logic [CNT_W-1:0] pend_next [TASK_COUNT];
    logic [MSG_W-1:0] word_reg  [TASK_COUNT];
    logic [MSG_W-1:0] word_next [TASK_COUNT];

    logic [IDX_W-1:0] idx_sel;
    logic [IDX_W-1:0] clr_sel;
    logic [IDX_W-1:0] rd_sel;

    assign idx_sel = ctl.idx[IDX_W-1:0];
    assign clr_sel = ctl.clr_idx[IDX_W-1:0];
    assign rd_sel  = ctl.rd_idx[IDX_W-1:0];

    // per-entry update: saturating pend count, message or/clear
    always_comb
    begin
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            pend_next[i] = pend_reg[i];
            word_next[i] = word_reg[i];
            if (idx_sel == IDX_W'(i))
            begin
                if (ctl.pend_inc && pend_reg[i] != CNT_MAX)
                begin
                    pend_next[i] = pend_reg[i] + CNT_W'(1);
                end
                if (ctl.pend_dec && pend_reg[i] != '0)
                begin
                    pend_next[i] = pend_reg[i] - CNT_W'(1);
                end
                if (ctl.dlv_en)
                begin
                    word_next[i] = word_reg[i] | ctl.msg;
                end
            end
            if (ctl.clr_en && clr_sel == IDX_W'(i))
            begin
                word_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                pend_reg[i] <= '0;
                word_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                pend_reg[i] <= pend_next[i];
                word_reg[i] <= word_next[i];
            end
        end
    end

    // status flags and the single message read port
    always_comb
    begin
        stat = '0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            stat.pend_zero[i] = (pend_reg[i] == '0);
            stat.pend_one[i]  = (pend_reg[i] == CNT_W'(1));
            stat.msg_zero[i]  = (word_reg[i] == '0);
        end
        stat.rd_word = word_reg[rd_sel];
    end

endmodule

>>> hw/rtl/bpts_sched_core.sv
// scheduler state, command decode and priority selection
module bpts_sched_core #(
    parameter int TASK_COUNT = bpts_pkg::TASK_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [3:0]                    func,
    input  logic [bpts_pkg::PRIO_W-1:0]   task_prio,
    input  logic [bpts_pkg::MSG_W-1:0]    msg_in,
    input  logic [bpts_pkg::TASK_MAX-1:0] created_mask,
    input  bpts_pkg::tbl_stat_t           tbl_stat,
    output bpts_pkg::tbl_ctl_t            tbl_ctl,
    output bpts_pkg::result_t             result
);
    import bpts_pkg::*;

    localparam logic [TASK_MAX-1:0] VALID_MASK = (TASK_COUNT >= TASK_MAX) ?
        {TASK_MAX{1'b1}} : TASK_MAX'((64'd1 << TASK_COUNT) - 64'd1);
    localparam logic [PRIO_W-1:0] TASK_LIMIT = PRIO_W'(TASK_COUNT);

    logic [TASK_MAX-1:0] ready_reg, ready_next;
    logic [PRIO_W-1:0]   cur_reg, cur_next;
    logic                started_reg, started_next;
    logic [CNT_W-1:0]    lock_reg, lock_next;

    func_t                 fn;
    logic [TASK_IDX_W-1:0] pi;
    logic [TASK_IDX_W-1:0] cur_idx;
    logic                  in_range;
    logic                  cur_live;
    logic                  range_fn;
    logic                  bad;
    logic                  created_p;
    logic [TASK_MAX-1:0]   p_bit;
    logic [TASK_MAX-1:0]   cur_bit;
    logic [TASK_MAX-1:0]   ready_mod;
    logic [PRIO_W-1:0]     top;
    logic                  top_live;
    logic                  resched;
    switch_t               sw;
    logic [MSG_W-1:0]      mout;

    // request decode
    always_comb
    begin
        fn        = func_t'(func);
        pi        = task_prio[TASK_IDX_W-1:0];
        cur_idx   = cur_reg[TASK_IDX_W-1:0];
        in_range  = (task_prio < TASK_LIMIT);
        cur_live  = (cur_reg < TASK_LIMIT);
        range_fn  = (fn == FN_SEND_T) || (fn == FN_SEND_I) || (fn == FN_PEND) ||
                    (fn == FN_RESUME) || (fn == FN_READY) || (fn == FN_UNREADY);
        bad       = range_fn && !in_range;
        created_p = created_mask[pi];
        p_bit     = TASK_MAX'(1) << pi;
        cur_bit   = TASK_MAX'(1) << cur_idx;
    end

    // ready bitmap changes ahead of selection
    always_comb
    begin
        ready_mod = ready_reg;
        if (!bad)
        begin
            case (fn)
                FN_SEND_T, FN_SEND_I:
                begin
                    if (created_p && tbl_stat.pend_zero[pi])
                    begin
                        ready_mod = ready_reg | p_bit;
                    end
                end
                FN_PEND, FN_UNREADY:
                begin
                    if (created_p)
                    begin
                        ready_mod = ready_reg & ~p_bit;
                    end
                end
                FN_RESUME:
                begin
                    if (created_p && (tbl_stat.pend_zero[pi] || tbl_stat.pend_one[pi]))
                    begin
                        ready_mod = ready_reg | p_bit;
                    end
                end
                FN_READY:
                begin
                    if (created_p)
                    begin
                        ready_mod = ready_reg | p_bit;
                    end
                end
                FN_GET:
                begin
                    if (cur_live && tbl_stat.msg_zero[cur_idx] && created_mask[cur_idx])
                    begin
                        ready_mod = ready_reg & ~cur_bit;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // top ready priority
    assign top      = first_set(ready_mod & VALID_MASK);
    assign top_live = (top != NO_TASK);
    assign resched  = top_live && (top != cur_reg);

    // selection, counters and table controls
    always_comb
    begin
        ready_next   = ready_mod;
        cur_next     = cur_reg;
        started_next = started_reg;
        lock_next    = lock_reg;
        sw           = SW_NONE;
        tbl_ctl          = '0;
        tbl_ctl.idx      = pi;
        tbl_ctl.msg      = msg_in;
        tbl_ctl.clr_idx  = cur_idx;
        if (!bad)
        begin
            case (fn)
                FN_START:
                begin
                    if (!started_reg)
                    begin
                        started_next = 1'b1;
                        cur_next     = top;
                        if (top_live)
                        begin
                            sw = SW_THREAD;
                        end
                    end
                end
                FN_SEND_T:
                begin
                    tbl_ctl.dlv_en = created_p;
                    if (resched)
                    begin
                        cur_next = top;
                        sw       = SW_THREAD;
                    end
                end
                FN_SEND_I:
                begin
                    tbl_ctl.dlv_en = created_p;
                    if (lock_reg == '0 && top_live && top < cur_reg)
                    begin
                        cur_next = top;
                        sw       = SW_IRQ;
                    end
                end
                FN_PEND:
                begin
                    tbl_ctl.pend_inc = 1'b1;
                end
                FN_RESUME:
                begin
                    tbl_ctl.pend_dec = 1'b1;
                end
                FN_GET:
                begin
                    if (resched)
                    begin
                        cur_next = top;
                        sw       = SW_THREAD;
                    end
                    if (cur_next < TASK_LIMIT)
                    begin
                        tbl_ctl.clr_en  = 1'b1;
                        tbl_ctl.clr_idx = cur_next[TASK_IDX_W-1:0];
                    end
                end
                FN_CLEAR:
                begin
                    tbl_ctl.clr_en = cur_live;
                end
                FN_LOCK:
                begin
                    if (lock_reg != CNT_MAX)
                    begin
                        lock_next = lock_reg + CNT_W'(1);
                    end
                end
                FN_UNLOCK:
                begin
                    if (lock_reg != '0)
                    begin
                        lock_next = lock_reg - CNT_W'(1);
                    end
                    if (resched)
                    begin
                        cur_next = top;
                        sw       = SW_THREAD;
                    end
                end
                FN_RESCHED:
                begin
                    if (resched)
                    begin
                        cur_next = top;
                        sw       = SW_THREAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (!step)
        begin
            tbl_ctl.dlv_en   = 1'b0;
            tbl_ctl.pend_inc = 1'b0;
            tbl_ctl.pend_dec = 1'b0;
            tbl_ctl.clr_en   = 1'b0;
        end
        // message read of the running task after get msg
        tbl_ctl.rd_idx = cur_next[TASK_IDX_W-1:0];
    end

    always_comb
    begin
        mout = '0;
        if (!bad && fn == FN_GET && cur_next < TASK_LIMIT)
        begin
            mout = tbl_stat.rd_word;
        end
    end

    // result of this request
    always_comb
    begin
        result.status       = bad ? ST_RANGE : ST_OK;
        result.switch_kind  = sw;
        result.running_prio = cur_next;
        result.msg_out      = mout;
        result.ready_bits   = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= '0;
            cur_reg     <= NO_TASK;
            started_reg <= 1'b0;
            lock_reg    <= '0;
        end
        else if (step)
        begin
            ready_reg   <= ready_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            lock_reg    <= lock_next;
        end
    end

endmodule
